// ----- rtl/ico_palette_pixel_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// ico_palette_pixel_decoder_assert
// Assertion macros of the icon palette pixel decoder.
// ----------------------------------------------------------------------------
`ifndef ICO_PALETTE_PIXEL_DECODER_ASSERT_SVH
`define ICO_PALETTE_PIXEL_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define ICOPD_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ICOPD_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ICOPD_ASSERT_IMP(name, ante, cons, msg)
`define ICOPD_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- rtl/icopd_pkg.sv -----
// ----------------------------------------------------------------------------
// icopd_pkg
// Shared types and constants of the icon palette pixel decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package icopd_pkg;

	localparam int MAX_DIMENSION = 256;
	localparam int PALETTE_DEPTH = 256;

	localparam int BYTE_W = 8;
	localparam int RGB_W  = 24;
	localparam int DIM_W  = 9;
	localparam int BPP_W  = 2;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// palette address width and entry counter width (counter reaches 256)
	localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int ENT_W  = 9;
	// column and row counters, with headroom for the 32-pixel round-up
	localparam int CNT_W  = $clog2(MAX_DIMENSION + 32) + 1;

	localparam logic [RGB_W-1:0] RGB_WHITE = 24'hFFFFFF;
	localparam logic [RGB_W-1:0] RGB_BLACK = 24'h000000;

	localparam logic [BPP_W-1:0] BPP_RESET    = 2'd2;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd32;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd32;

	typedef enum logic [1:0] {
		PH_PALETTE,
		PH_BITMAP,
		PH_MASK
	} phase_t;

	typedef enum logic [1:0] {
		DEPTH_1 = 2'd0,
		DEPTH_4 = 2'd1,
		DEPTH_8 = 2'd2
	} depth_t;

	typedef enum logic [1:0] {
		REG_BPP,
		REG_WIDTH,
		REG_HEIGHT,
		REG_MASK_EN
	} reg_idx_t;

	typedef enum logic [1:0] {
		JOB_1BPP,
		JOB_4BPP,
		JOB_8BPP,
		JOB_MASK
	} job_kind_t;

	typedef struct packed {
		logic [BPP_W-1:0] bpp_code;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             mask_en;
	} cfg_t;

	// zero reads as one, anything above the limit saturates
	function automatic logic [CNT_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [CNT_W-1:0] ext;
		ext = CNT_W'(v);
		if (ext == '0) begin
			return CNT_W'(1);
		end else if (ext > CNT_W'(MAX_DIMENSION)) begin
			return CNT_W'(MAX_DIMENSION);
		end
		return ext;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/icopd_if.sv -----
// ----------------------------------------------------------------------------
// icopd_if
// Valid/ready channels of the decoder: data bytes in, pixels out.
// ----------------------------------------------------------------------------
`default_nettype none

interface icopd_byte_if import icopd_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface icopd_pixel_if import icopd_pkg::*;;
	logic             valid;
	logic             ready;
	logic [RGB_W-1:0] pixel_rgb;
	logic             pixel_opaque;
	logic             is_mask_pixel;
	logic             is_padding;
	logic             frame_done;
	logic             last_of_byte;

	modport source (
		output valid, output pixel_rgb, output pixel_opaque, output is_mask_pixel,
		output is_padding, output frame_done, output last_of_byte, input ready
	);
	modport sink (
		input valid, input pixel_rgb, input pixel_opaque, input is_mask_pixel,
		input is_padding, input frame_done, input last_of_byte, output ready
	);
endinterface

`default_nettype wire

// ----- rtl/icopd_ram.sv -----
// ----------------------------------------------------------------------------
// icopd_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module icopd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic                                      re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/icopd_cfg.sv -----
// ----------------------------------------------------------------------------
// icopd_cfg
// APB register file: pixel depth, width, height and mask enable.
// ----------------------------------------------------------------------------
`default_nettype none

module icopd_cfg import icopd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bpp_code <= BPP_RESET;
			cfg_q.width    <= WIDTH_RESET;
			cfg_q.height   <= HEIGHT_RESET;
			cfg_q.mask_en  <= 1'b1;
		end else if (wr_en) begin
			case (reg_sel)
				REG_BPP:     cfg_q.bpp_code <= pwdata[BPP_W-1:0];
				REG_WIDTH:   cfg_q.width    <= pwdata[DIM_W-1:0];
				REG_HEIGHT:  cfg_q.height   <= pwdata[DIM_W-1:0];
				REG_MASK_EN: cfg_q.mask_en  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_BPP:     prdata = APB_DW'(cfg_q.bpp_code);
			REG_WIDTH:   prdata = APB_DW'(cfg_q.width);
			REG_HEIGHT:  prdata = APB_DW'(cfg_q.height);
			REG_MASK_EN: prdata = APB_DW'(cfg_q.mask_en);
			default:     prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/ico_palette_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// ico_palette_pixel_decoder
// Icon frame data decoder: palette load, XOR bitmap unpack, AND mask expand.
// The first pixel of a byte leaves through the job register, s2 and s3, in order.
// Throughput: one pixel per cycle while the pixel channel is ready; a byte
// gives 8 pixels at 1 bpp and in the mask, 2 at 4 bpp, 1 at 8 bpp. A new
// frame's first palette byte waits for the previous byte's job to drain.
// Reset clears control; palette is unset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ico_palette_pixel_decoder_assert.svh"

module ico_palette_pixel_decoder import icopd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	icopd_byte_if.sink             data_ch,
	icopd_pixel_if.source          pixel_ch
);

	cfg_t cfg;

	// frame state
	phase_t           phase_q, phase_d;
	logic [ENT_W-1:0] ent_q, ent_d;
	logic [1:0]       quad_q, quad_d;
	logic [15:0]      partial_q, partial_d;
	logic [CNT_W-1:0] col_q, col_d;
	logic [CNT_W-1:0] row_q, row_d;

	logic [CNT_W-1:0] w_eff, h_eff, padded, col_sum, row_inc;
	logic [3:0]       n_pix;
	logic [ENT_W-1:0] colours, ent_inc;
	logic [BYTE_W-1:0] in_byte;
	logic             in_fire;
	logic             job_load, done_d;
	job_kind_t        kind_d;

	// per-byte job
	logic             job_valid_q;
	job_kind_t        job_kind_q;
	logic [BYTE_W-1:0] job_byte_q;
	logic [CNT_W-1:0] job_col_q;
	logic [2:0]       job_k_q;
	logic             job_done_q;

	logic [BYTE_W-1:0] idx;
	logic             k_last, bit_sel, pad_pix, issue, job_free;

	// stage 2 (aligned with palette read data) and output stage 3
	logic valid_s2, is_mask_s2, set_s2, pad_s2, last_s2, done_s2, idx_ok_s2;
	logic valid_s3, opaque_s3, is_mask_s3, pad_s3, last_s3, done_s3;
	logic [RGB_W-1:0] rgb_s3;
	logic s2_free, out_free;

	// palette RAM
	logic              pal_we, pal_re;
	logic [PAL_AW-1:0] pal_waddr, pal_raddr;
	logic [RGB_W-1:0]  pal_wdata, pal_rdata;

	icopd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	icopd_ram #(
		.WIDTH (RGB_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pal_waddr),
		.wdata (pal_wdata),
		.re    (pal_re),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	assign in_byte  = data_ch.data_byte;
	assign in_fire  = data_ch.valid && data_ch.ready;
	assign out_free = !valid_s3 || pixel_ch.ready;
	assign s2_free  = !valid_s2 || out_free;
	assign issue    = job_valid_q && s2_free;
	assign job_free = !job_valid_q || (issue && k_last);

	// palette writes wait until no job still needs a palette read
	assign data_ch.ready = (phase_q == PH_PALETTE) ? !job_valid_q : job_free;

	assign w_eff = clamp_dim(cfg.width);
	assign h_eff = clamp_dim(cfg.height);

	// pixels per byte, padded row length and palette size for this beat
	always_comb begin
		if (phase_q == PH_MASK) begin
			kind_d  = JOB_MASK;
			n_pix   = 4'd8;
			padded  = (w_eff + CNT_W'(31)) & ~CNT_W'(31);
			colours = ENT_W'(256);
		end else begin
			case (cfg.bpp_code)
				DEPTH_1: begin
					kind_d  = JOB_1BPP;
					n_pix   = 4'd8;
					padded  = (w_eff + CNT_W'(31)) & ~CNT_W'(31);
					colours = ENT_W'(2);
				end
				DEPTH_4: begin
					kind_d  = JOB_4BPP;
					n_pix   = 4'd2;
					padded  = (w_eff + CNT_W'(7)) & ~CNT_W'(7);
					colours = ENT_W'(16);
				end
				default: begin
					kind_d  = JOB_8BPP;
					n_pix   = 4'd1;
					padded  = (w_eff + CNT_W'(3)) & ~CNT_W'(3);
					colours = ENT_W'(256);
				end
			endcase
		end
	end

	assign col_sum = col_q + CNT_W'(n_pix);
	assign row_inc = row_q + CNT_W'(1);
	assign ent_inc = ent_q + ENT_W'(1);

	assign pal_waddr = ent_q[PAL_AW-1:0];
	assign pal_wdata = {in_byte, partial_q};

	always_comb begin
		phase_d   = phase_q;
		ent_d     = ent_q;
		quad_d    = quad_q;
		partial_d = partial_q;
		col_d     = col_q;
		row_d     = row_q;
		pal_we    = 1'b0;
		job_load  = 1'b0;
		done_d    = 1'b0;
		if (in_fire) begin
			case (phase_q)
				PH_PALETTE: begin
					case (quad_q)
						2'd0: partial_d = {8'h00, in_byte};
						2'd1: partial_d = {in_byte, partial_q[7:0]};
						2'd2: pal_we = (ent_q < ENT_W'(PALETTE_DEPTH));
						default: ;
					endcase
					if (quad_q == 2'd3) begin
						quad_d = 2'd0;
						ent_d  = ent_inc;
						if (ent_inc >= colours) begin
							phase_d = PH_BITMAP;
							col_d   = '0;
							row_d   = '0;
						end
					end else begin
						quad_d = quad_q + 2'd1;
					end
				end
				PH_BITMAP, PH_MASK: begin
					job_load = 1'b1;
					col_d    = col_sum;
					if (col_sum >= padded) begin
						col_d = '0;
						row_d = row_inc;
						if (row_inc >= h_eff) begin
							row_d = '0;
							if (phase_q == PH_BITMAP && cfg.mask_en) begin
								phase_d = PH_MASK;
							end else begin
								// end of frame: back to palette loading
								done_d    = 1'b1;
								phase_d   = PH_PALETTE;
								ent_d     = '0;
								quad_d    = 2'd0;
								partial_d = '0;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_PALETTE;
			ent_q     <= '0;
			quad_q    <= 2'd0;
			partial_q <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else begin
			phase_q   <= phase_d;
			ent_q     <= ent_d;
			quad_q    <= quad_d;
			partial_q <= partial_d;
			col_q     <= col_d;
			row_q     <= row_d;
		end
	end

	// job register: one byte being split into pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
		end else if (job_load) begin
			job_valid_q <= 1'b1;
		end else if (issue && k_last) begin
			job_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_load) begin
			job_kind_q <= kind_d;
			job_byte_q <= in_byte;
			job_col_q  <= col_q;
			job_k_q    <= 3'd0;
			job_done_q <= done_d;
		end else if (issue) begin
			job_k_q <= job_k_q + 3'd1;
		end
	end

	// msb-first pixel select
	assign bit_sel = job_byte_q[3'd7 - job_k_q];
	assign pad_pix = (job_col_q + CNT_W'(job_k_q)) >= w_eff;

	always_comb begin
		case (job_kind_q)
			JOB_1BPP: begin
				idx    = {7'd0, bit_sel};
				k_last = (job_k_q == 3'd7);
			end
			JOB_4BPP: begin
				idx    = job_k_q[0] ? {4'd0, job_byte_q[3:0]} : {4'd0, job_byte_q[7:4]};
				k_last = job_k_q[0];
			end
			JOB_8BPP: begin
				idx    = job_byte_q;
				k_last = 1'b1;
			end
			JOB_MASK: begin
				idx    = '0;
				k_last = (job_k_q == 3'd7);
			end
			default: begin
				idx    = '0;
				k_last = 1'b1;
			end
		endcase
	end

	assign pal_re    = issue && (job_kind_q != JOB_MASK);
	assign pal_raddr = idx[PAL_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			is_mask_s2 <= (job_kind_q == JOB_MASK);
			set_s2     <= bit_sel;
			pad_s2     <= pad_pix;
			last_s2    <= k_last;
			done_s2    <= k_last && job_done_q;
			idx_ok_s2  <= (ENT_W'(idx) < ENT_W'(PALETTE_DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (out_free) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && out_free) begin
			if (is_mask_s2) begin
				rgb_s3    <= set_s2 ? RGB_BLACK : RGB_WHITE;
				opaque_s3 <= !set_s2;
			end else begin
				rgb_s3    <= idx_ok_s2 ? pal_rdata : RGB_BLACK;
				opaque_s3 <= 1'b1;
			end
			is_mask_s3 <= is_mask_s2;
			pad_s3     <= pad_s2;
			last_s3    <= last_s2;
			done_s3    <= done_s2;
		end
	end

	assign pixel_ch.valid         = valid_s3;
	assign pixel_ch.pixel_rgb     = rgb_s3;
	assign pixel_ch.pixel_opaque  = opaque_s3;
	assign pixel_ch.is_mask_pixel = is_mask_s3;
	assign pixel_ch.is_padding    = pad_s3;
	assign pixel_ch.frame_done    = done_s3;
	assign pixel_ch.last_of_byte  = last_s3;

	`ICOPD_ASSERT_IMP(a_mask_colour, valid_s3 && is_mask_s3,
		(opaque_s3 ? (rgb_s3 == RGB_WHITE) : (rgb_s3 == RGB_BLACK)),
		"mask pixel colour does not match its opacity")

	`ICOPD_ASSERT_IMP(a_done_is_last, valid_s3 && done_s3, last_s3,
		"frame end flagged on a pixel that does not close its byte")

	`ICOPD_ASSERT_IMP(a_done_phase, job_valid_q && job_done_q, phase_q == PH_PALETTE,
		"frame-ending job in flight while not back in palette loading")

	`ICOPD_ASSERT_NEXT(a_rdata_hold, valid_s2 && !out_free, $stable(pal_rdata),
		"palette read data changed under a stalled pixel")

endmodule

`default_nettype wire

// ----- verif/ico_palette_pixel_decoder_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ico_palette_pixel_decoder_tb
// Feeds icon frames (palette, XOR bitmap, optional AND mask) byte by byte
// through the data channel at several depths and sizes, predicts every pixel
// with a local decoder model and compares each pixel beat field by field.
// Register writes go through the APB port between frames and are read back.
// ----------------------------------------------------------------------------

module ico_palette_pixel_decoder_tb;
	import icopd_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int LONG_HOLD      = 300;
	localparam int RANDOM_BYTES   = 130;
	localparam logic [BPP_W-1:0] DEPTH_CODE3 = 2'd3;

	// palette (2 entries), two bitmap rows, two mask rows at 1 bpp, width 1
	localparam logic [24*8-1:0] DIRECTED_STREAM =
		192'h000000FF_FFFFFF00_807F00FF_55AA01FE_FF00807F_01FE55AA;

	typedef struct packed {
		logic [RGB_W-1:0] rgb;
		logic             opaque;
		logic             mask_px;
		logic             pad;
		logic             frame_end;
		logic             last_px;
	} pixel_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	icopd_byte_if  byte_ch ();
	icopd_pixel_if pix_ch ();

	ico_palette_pixel_decoder uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.data_ch  (byte_ch),
		.pixel_ch (pix_ch)
	);

	logic [BYTE_W-1:0] pending_bytes[$];
	pixel_t            expected_pixels[$];
	int                queued_count;
	int                fail_count;
	int                pix_beats;
	int                stall_cycles;
	bit                byte_beat;
	bit                pixel_beat;

	int in_gap, in_calm, out_hold, out_calm, long_holds;

	// decoder model state
	cfg_t             cur_cfg;
	phase_t           dec_phase;
	logic [RGB_W-1:0] pal_mem [PALETTE_DEPTH];
	int               pal_fill;
	int               quad_pos;
	logic [15:0]      part_bg;
	int               col_pos;
	int               row_pos;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int depth_bits(input logic [BPP_W-1:0] code);
		if (code == DEPTH_1) return 1;
		if (code == DEPTH_4) return 4;
		return 8;
	endfunction

	function automatic int dim_eff(input logic [DIM_W-1:0] v);
		if (v == '0) return 1;
		if (int'(v) > MAX_DIMENSION) return MAX_DIMENSION;
		return int'(v);
	endfunction

	function automatic void start_frame();
		dec_phase = PH_PALETTE;
		pal_fill  = 0;
		quad_pos  = 0;
		part_bg   = '0;
		col_pos   = 0;
		row_pos   = 0;
	endfunction

	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		int     bits, w, h, padded, n, k, colours;
		bit     done;
		bit     set;
		logic [7:0] idx;
		pixel_t px [8];
		bits = depth_bits(cur_cfg.bpp_code);
		w    = dim_eff(cur_cfg.width);
		h    = dim_eff(cur_cfg.height);
		done = 1'b0;
		n    = 0;
		case (dec_phase)
			PH_BITMAP: begin
				padded = ((w * bits + 31) / 32 * 32) / bits;
				n = 8 / bits;
				for (k = 0; k < n; k++) begin
					if (bits == 1) idx = 8'(b[7-k]);
					else if (bits == 4) idx = (k == 0) ? 8'(b[7:4]) : 8'(b[3:0]);
					else idx = b;
					px[k] = '0;
					px[k].rgb    = pal_mem[idx];
					px[k].opaque = 1'b1;
					px[k].pad    = (col_pos >= w);
					col_pos++;
				end
				if (col_pos >= padded) begin
					col_pos = 0;
					row_pos++;
					if (row_pos >= h) begin
						row_pos = 0;
						if (cur_cfg.mask_en) dec_phase = PH_MASK;
						else done = 1'b1;
					end
				end
			end
			PH_MASK: begin
				padded = (w + 31) / 32 * 32;
				n = 8;
				for (k = 0; k < n; k++) begin
					set = b[7-k];
					px[k] = '0;
					px[k].rgb     = set ? RGB_BLACK : RGB_WHITE;
					px[k].opaque  = !set;
					px[k].mask_px = 1'b1;
					px[k].pad     = (col_pos >= w);
					col_pos++;
				end
				if (col_pos >= padded) begin
					col_pos = 0;
					row_pos++;
					if (row_pos >= h) done = 1'b1;
				end
			end
			default: begin
				colours = 1 << bits;
				case (quad_pos)
					0: part_bg = {8'h00, b};
					1: part_bg[15:8] = b;
					2: if (pal_fill < PALETTE_DEPTH) pal_mem[pal_fill] = {b, part_bg};
					default: ;
				endcase
				// fourth byte of each entry is unused
				if (quad_pos >= 3) begin
					quad_pos = 0;
					pal_fill++;
					if (pal_fill >= colours) begin
						dec_phase = PH_BITMAP;
						col_pos = 0;
						row_pos = 0;
					end
				end else begin
					quad_pos++;
				end
			end
		endcase
		if (n > 0) begin
			px[n-1].last_px   = 1'b1;
			px[n-1].frame_end = done;
			for (k = 0; k < n; k++) expected_pixels.push_back(px[k]);
			if (done) start_frame();
		end
	endfunction

	function automatic void check_field(input string name, input logic [RGB_W-1:0] want_v,
			input logic [RGB_W-1:0] got);
		if (got !== want_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got);
			fail_count++;
		end
	endfunction

	// mostly short gaps, a few long ones, and now and then a calm stretch with none
	function automatic int next_gap(inout int calm, input int idle_pct);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 63) == 0) begin
			calm = $urandom_range(40, 160);
			return 0;
		end
		if ($urandom_range(0, 99) >= idle_pct) return 0;
		r = $urandom_range(0, 19);
		if (r < 15) return $urandom_range(1, 3);
		if (r < 19) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [BYTE_W-1:0] rand_byte();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return 8'h00;
		if (r == 1) return 8'hFF;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic void push_byte(input logic [BYTE_W-1:0] b);
		pending_bytes.push_back(b);
		queued_count++;
	endfunction

	// palette, bitmap and mask bytes of one frame at the given setting
	function automatic void queue_frame(input cfg_t c);
		int bits, w, h;
		bits = depth_bits(c.bpp_code);
		w    = dim_eff(c.width);
		h    = dim_eff(c.height);
		repeat (4 << bits) push_byte(rand_byte());
		repeat (h * ((w * bits + 31) / 32) * 4) push_byte(rand_byte());
		if (c.mask_en) repeat (h * ((w + 31) / 32) * 4) push_byte(rand_byte());
	endfunction

	function automatic cfg_t random_cfg();
		cfg_t c;
		int   r;
		c.bpp_code = $urandom_range(0, 1) ? DEPTH_4 : DEPTH_1;
		r = $urandom_range(0, 9);
		if (r == 0) c.width = '0;
		else if (r == 1) c.width = DIM_W'($urandom_range(257, 511));
		else if (r == 2) c.width = DIM_W'(MAX_DIMENSION);
		else c.width = DIM_W'($urandom_range(1, 48));
		if (dim_eff(c.width) > 64) c.height = DIM_W'($urandom_range(0, 1));
		else if ($urandom_range(0, 9) == 0) c.height = '0;
		else c.height = DIM_W'($urandom_range(1, 3));
		c.mask_en = 1'($urandom_range(0, 1));
		return c;
	endfunction

	task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [APB_DW-1:0] wdata,
			output logic [APB_DW-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= APB_AW'(idx) << 2;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic reg_check(input reg_idx_t idx, input logic [APB_DW-1:0] want_v);
		logic [APB_DW-1:0] rd;
		apb_xfer(1'b0, idx, '0, rd);
		if (rd !== want_v) begin
			$error("register %s: expected %0h, got %0h", idx.name(), want_v, rd);
			fail_count++;
		end
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
		logic [APB_DW-1:0] rd;
		apb_xfer(1'b1, idx, val, rd);
		reg_check(idx, val);
	endtask

	task automatic set_config(input cfg_t c);
		reg_write(REG_BPP, APB_DW'(c.bpp_code));
		reg_write(REG_WIDTH, APB_DW'(c.width));
		reg_write(REG_HEIGHT, APB_DW'(c.height));
		reg_write(REG_MASK_EN, APB_DW'(c.mask_en));
		cur_cfg = c;
	endtask

	// sampled at the rising edge, where both channels are stable
	task automatic drain();
		@(posedge clk);
		while (pending_bytes.size() > 0 || byte_ch.valid || expected_pixels.size() > 0)
			@(posedge clk);
		// palette bytes leave nothing to wait for, so give the pipe time to empty
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// palette loaded at 1 bpp, then the depth changes before the bitmap;
	// bitmap indexes stay within the two loaded entries
	task automatic queue_split_frame(input logic [BPP_W-1:0] code);
		int k;
		drain();
		set_config('{DEPTH_1, 9'd3, 9'd2, 1'b1});
		repeat (8) push_byte(rand_byte());
		drain();
		set_config('{code, 9'd3, 9'd2, 1'b1});
		for (k = 0; k < 8; k++) push_byte(BYTE_W'($urandom_range(0, 1)));
		repeat (8) push_byte(rand_byte());
	endtask

	// byte sender
	always @(negedge clk) begin
		if (arst_n && (!byte_ch.valid || byte_beat)) begin
			if (in_gap > 0) begin
				byte_ch.valid <= 1'b0;
				in_gap--;
			end else if (pending_bytes.size() > 0) begin
				byte_ch.data_byte <= pending_bytes.pop_front();
				byte_ch.valid     <= 1'b1;
				in_gap = next_gap(in_calm, 40);
			end else begin
				byte_ch.valid <= 1'b0;
			end
		end
	end

	// pixel receiver, with a long hold-off now and then while bytes keep coming
	always @(negedge clk) begin : pixel_ready
		int gap;
		if (arst_n) begin
			if (out_hold > 0) begin
				pix_ch.ready <= 1'b0;
				out_hold--;
			end else if (long_holds < 2 && pix_beats >= 600 * (long_holds + 1)
					&& pending_bytes.size() > 24) begin
				pix_ch.ready <= 1'b0;
				out_hold = LONG_HOLD - 1;
				long_holds++;
			end else begin
				gap = next_gap(out_calm, 15);
				if (gap == 0) begin
					pix_ch.ready <= 1'b1;
				end else begin
					pix_ch.ready <= 1'b0;
					out_hold = gap - 1;
				end
			end
		end
	end

	// beat monitor, pixel checker and watchdog
	always @(posedge clk) begin : beat_monitor
		pixel_t want;
		if (arst_n) begin
			byte_beat  = byte_ch.valid && byte_ch.ready;
			pixel_beat = pix_ch.valid && pix_ch.ready;
			if (byte_beat) decode_byte(byte_ch.data_byte);
			if (pixel_beat) begin
				pix_beats++;
				if (expected_pixels.size() == 0) begin
					$error("pixel beat with nothing expected: rgb %06h", pix_ch.pixel_rgb);
					fail_count++;
				end else begin
					want = expected_pixels.pop_front();
					check_field("pixel_rgb", want.rgb, pix_ch.pixel_rgb);
					check_field("pixel_opaque", RGB_W'(want.opaque), RGB_W'(pix_ch.pixel_opaque));
					check_field("is_mask_pixel", RGB_W'(want.mask_px), RGB_W'(pix_ch.is_mask_pixel));
					check_field("is_padding", RGB_W'(want.pad), RGB_W'(pix_ch.is_padding));
					check_field("frame_done", RGB_W'(want.frame_end), RGB_W'(pix_ch.frame_done));
					check_field("last_of_byte", RGB_W'(want.last_px), RGB_W'(pix_ch.last_of_byte));
				end
			end
			if (byte_beat || pixel_beat) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		cfg_t c;
		cfg_t corner_cfgs [3];
		int   i;
		int   random_start;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		pix_ch.ready      = 1'b0;
		arst_n            = 1'b0;
		byte_beat         = 1'b0;
		pixel_beat        = 1'b0;
		queued_count      = 0;
		fail_count        = 0;
		pix_beats         = 0;
		stall_cycles      = 0;
		in_gap            = 0;
		in_calm           = 0;
		out_hold          = 0;
		out_calm          = 0;
		long_holds        = 0;
		cur_cfg           = '{BPP_RESET, WIDTH_RESET, HEIGHT_RESET, 1'b1};
		start_frame();

		corner_cfgs[0] = '{DEPTH_4, 9'd0, 9'd0, 1'b1};      // zero sizes read as one
		corner_cfgs[1] = '{DEPTH_1, 9'd511, 9'd1, 1'b0};    // width saturates, no mask
		corner_cfgs[2] = '{DEPTH_1, 9'd256, 9'd1, 1'b1};

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		reg_check(REG_BPP, APB_DW'(BPP_RESET));
		reg_check(REG_WIDTH, APB_DW'(WIDTH_RESET));
		reg_check(REG_HEIGHT, APB_DW'(HEIGHT_RESET));
		reg_check(REG_MASK_EN, APB_DW'(1'b1));

		// black/white palette, then extreme bit patterns in bitmap and mask
		set_config('{DEPTH_1, 9'd1, 9'd2, 1'b1});
		for (i = 23; i >= 0; i--) push_byte(DIRECTED_STREAM[i*8 +: 8]);

		foreach (corner_cfgs[i]) begin
			drain();
			set_config(corner_cfgs[i]);
			queue_frame(corner_cfgs[i]);
		end

		// spare depth code and 8 bpp unpacking without a full 256-entry palette
		queue_split_frame(DEPTH_CODE3);
		queue_split_frame(DEPTH_8);

		random_start = queued_count;
		while (queued_count - random_start < RANDOM_BYTES) begin
			drain();
			c = random_cfg();
			set_config(c);
			// one or two back-to-back frames at one setting
			repeat ($urandom_range(1, 2)) queue_frame(c);
		end

		drain();
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
